FILE: design/gtl_pkg.sv
// Shared types and constants of the glyph text layout block.
// Used by glyph_text_layout_top; no dependencies of its own.
`timescale 1ns / 1ps

package gtl_pkg;

  // Default depth of the glyph table
  localparam int GLYPH_ENTRIES_DEF = 256;

  // Result queue depth, a power of two so the pointers wrap on their own
  localparam int RES_DEPTH = 8;

  // APB address width: eight 32-bit registers at byte address 4*i
  localparam int PADDR_W = 5;

  // Register indexes
  localparam logic [2:0] REG_FIRST_CODE  = 3'd0;
  localparam logic [2:0] REG_GLYPH_COUNT = 3'd1;
  localparam logic [2:0] REG_LINE_HEIGHT = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd4;
  localparam logic [2:0] REG_DRAW_COLOR  = 3'd5;
  localparam logic [2:0] REG_FONT_READY  = 3'd6;
  localparam logic [2:0] REG_ATLAS_READY = 3'd7;

  // Register reset values that are not zero
  localparam logic [7:0]  FIRST_CODE_RST = 8'd32;
  localparam logic [31:0] DRAW_COLOR_RST = 32'hFFFF_FFFF;

  // Command and result codes
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_TEXT     = 1'b1;
  localparam logic KIND_QUAD    = 1'b0;
  localparam logic KIND_MEASURE = 1'b1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // Saturation limits
  localparam logic [18:0] LINE_MAX   = 19'h7FFFF;
  localparam logic [19:0] HEIGHT_MAX = 20'hFFFFF;

  // One result item as it sits in the result queue
  typedef struct packed {
    logic               kind;
    logic signed [19:0] centre_x;
    logic signed [19:0] centre_y;
    logic [15:0]        quad_width;
    logic [15:0]        quad_height;
    logic [63:0]        atlas_rect;
    logic [31:0]        color;
    logic [18:0]        text_width;
    logic [19:0]        text_height;
    logic               last_out;
  } result_t;

  // Clamp a widened coordinate sum to signed 20 bits
  function automatic logic signed [19:0] sat_s20(input logic signed [22:0] v);
    if (v > 23'sd524287) begin
      return 20'sh7FFFF;
    end else if (v < -23'sd524288) begin
      return 20'sh80000;
    end
    return v[19:0];
  endfunction

endpackage

FILE: design/gtl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module gtl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; the read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/glyph_text_layout_top.sv
// Top level of the glyph text layout block: config registers, glyph tables,
// layout stage and result queue. Depends on gtl_pkg and gtl_ram.
`timescale 1ns / 1ps

// The block takes one request per cycle unless stalled, either a glyph table
// load or a text byte. A text byte reads the glyph tables in its accept cycle
// and is laid out in the next one, so its results enter the result queue at
// the end of that cycle. A byte makes at most two results (a quad and, on the
// last byte, the measurement); the 8-entry result queue sends one result per
// cycle while result_stall is low, and item_stall rises whenever the queue
// could not absorb two results for each byte in flight. With a consumer that
// never stalls, strings whose bytes each give at most one result stream at
// one byte per cycle. The glyph tables need no clearing after reset.
module glyph_text_layout_top #(
  parameter int GLYPH_ENTRIES = gtl_pkg::GLYPH_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gtl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // request channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        cmd,
  input  logic [7:0]                  code,
  input  logic [15:0]                 advance_in,
  input  logic signed [15:0]          offset_x_in,
  input  logic signed [15:0]          offset_y_in,
  input  logic [15:0]                 width_in,
  input  logic [15:0]                 height_in,
  input  logic [63:0]                 atlas_rect_in,
  input  logic                        last_char,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        kind,
  output logic signed [19:0]          centre_x,
  output logic signed [19:0]          centre_y,
  output logic [15:0]                 quad_width,
  output logic [15:0]                 quad_height,
  output logic [63:0]                 atlas_rect,
  output logic [31:0]                 color,
  output logic [18:0]                 text_width,
  output logic [19:0]                 text_height,
  output logic                        last_out
);

  localparam int AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int PW = $clog2(gtl_pkg::RES_DEPTH);
  localparam int CW = $clog2(gtl_pkg::RES_DEPTH + 1);
  localparam int GM_W = 80;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [7:0]         first_code;
  logic [8:0]         glyph_count;
  logic [15:0]        line_pitch;
  logic signed [19:0] origin_x;
  logic signed [19:0] origin_y;
  logic [31:0]        draw_color;
  logic               font_ready;
  logic               atlas_ready;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_code  <= gtl_pkg::FIRST_CODE_RST;
      glyph_count <= '0;
      line_pitch  <= '0;
      origin_x    <= '0;
      origin_y    <= '0;
      draw_color  <= gtl_pkg::DRAW_COLOR_RST;
      font_ready  <= 1'b0;
      atlas_ready <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        gtl_pkg::REG_FIRST_CODE:  first_code  <= pwdata[7:0];
        gtl_pkg::REG_GLYPH_COUNT: glyph_count <= pwdata[8:0];
        gtl_pkg::REG_LINE_HEIGHT: line_pitch  <= pwdata[15:0];
        gtl_pkg::REG_ORIGIN_X:    origin_x    <= pwdata[19:0];
        gtl_pkg::REG_ORIGIN_Y:    origin_y    <= pwdata[19:0];
        gtl_pkg::REG_DRAW_COLOR:  draw_color  <= pwdata;
        gtl_pkg::REG_FONT_READY:  font_ready  <= pwdata[0];
        gtl_pkg::REG_ATLAS_READY: atlas_ready <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (paddr[4:2])
      gtl_pkg::REG_FIRST_CODE:  prdata = {24'b0, first_code};
      gtl_pkg::REG_GLYPH_COUNT: prdata = {23'b0, glyph_count};
      gtl_pkg::REG_LINE_HEIGHT: prdata = {16'b0, line_pitch};
      gtl_pkg::REG_ORIGIN_X:    prdata = {12'b0, origin_x};
      gtl_pkg::REG_ORIGIN_Y:    prdata = {12'b0, origin_y};
      gtl_pkg::REG_DRAW_COLOR:  prdata = draw_color;
      gtl_pkg::REG_FONT_READY:  prdata = {31'b0, font_ready};
      gtl_pkg::REG_ATLAS_READY: prdata = {31'b0, atlas_ready};
      default:                  prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Accept stage: decode the byte, write or read the glyph tables
  // ------------------------------------------------------------------
  logic            item_accept;
  logic [8:0]      idx_wide;
  logic            mapped;
  logic            load_we;
  logic [GM_W-1:0] gm_wdata;
  logic [GM_W-1:0] gm_rdata;
  logic [63:0]     atlas_rdata;

  assign item_accept = item_valid && !item_stall;
  assign idx_wide    = {1'b0, code} - {1'b0, first_code};
  assign mapped      = (code != gtl_pkg::NEWLINE_CODE) && (code >= first_code)
                       && (idx_wide < glyph_count) && (idx_wide < 9'(GLYPH_ENTRIES));
  assign load_we     = item_accept && (cmd == gtl_pkg::CMD_LOAD)
                       && ({1'b0, code} < 9'(GLYPH_ENTRIES));
  assign gm_wdata    = {height_in, width_in, offset_y_in, offset_x_in, advance_in};

  gtl_ram #(
    .WIDTH (GM_W),
    .DEPTH (GLYPH_ENTRIES)
  ) u_metrics_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (code[AW-1:0]),
    .wdata (gm_wdata),
    .raddr (idx_wide[AW-1:0]),
    .rdata (gm_rdata)
  );

  gtl_ram #(
    .WIDTH (64),
    .DEPTH (GLYPH_ENTRIES)
  ) u_atlas_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (code[AW-1:0]),
    .wdata (atlas_rect_in),
    .raddr (idx_wide[AW-1:0]),
    .rdata (atlas_rdata)
  );

  // Carry the text byte's control bits to the layout stage
  logic s1_valid;
  logic s1_newline;
  logic s1_mapped;
  logic s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= item_accept && (cmd == gtl_pkg::CMD_TEXT);
    end
  end

  always_ff @(posedge clk) begin
    s1_newline <= (code == gtl_pkg::NEWLINE_CODE);
    s1_mapped  <= mapped;
    s1_last    <= last_char;
  end

  // ------------------------------------------------------------------
  // Layout stage: place the quad, advance the pen, form the measurement
  // ------------------------------------------------------------------
  logic [18:0] line_width, line_width_next;
  logic [18:0] widest, widest_next;
  logic [19:0] pen_down, pen_down_next;
  logic [19:0] height_sum, height_sum_next;

  logic [15:0]        g_adv;
  logic signed [15:0] g_offx;
  logic signed [15:0] g_offy;
  logic [15:0]        g_w;
  logic [15:0]        g_h;
  logic               font_ok;
  logic               quad_hit;
  logic               meas_hit;
  logic signed [22:0] cx_sum;
  logic signed [22:0] cy_sum;
  logic [19:0]        lw_add;
  logic [20:0]        pd_add;
  logic [20:0]        hs_add;
  logic [18:0]        lw_fin;
  logic [18:0]        wd_fin;
  logic [19:0]        hs_fin;
  logic [20:0]        th_add;
  logic [19:0]        th_sat;
  gtl_pkg::result_t   res_quad;
  gtl_pkg::result_t   res_meas;

  assign g_adv  = gm_rdata[15:0];
  assign g_offx = gm_rdata[31:16];
  assign g_offy = gm_rdata[47:32];
  assign g_w    = gm_rdata[63:48];
  assign g_h    = gm_rdata[79:64];

  assign font_ok  = font_ready && (glyph_count != 9'd0);
  assign quad_hit = s1_valid && !s1_newline && s1_mapped && (g_w != 16'd0)
                    && (g_h != 16'd0) && font_ok && atlas_ready;
  assign meas_hit = s1_valid && s1_last;

  // Centre is pen plus offset plus half the size, rounded down
  assign cx_sum = 23'(origin_x) + 23'(line_width) + 23'(g_offx) + 23'(g_w[15:1]);
  assign cy_sum = 23'(origin_y) + 23'(pen_down) + 23'(g_offy) + 23'(g_h[15:1]);

  assign lw_add = 20'(line_width) + 20'(g_adv);
  assign pd_add = 21'(pen_down) + 21'(line_pitch);
  assign hs_add = 21'(height_sum) + 21'(line_pitch);

  // Update the pen and line tracking
  always_comb begin
    lw_fin          = line_width;
    widest_next     = widest;
    pen_down_next   = pen_down;
    height_sum_next = height_sum;
    if (s1_valid) begin
      if (s1_newline) begin
        if (line_width > widest) begin
          widest_next = line_width;
        end
        lw_fin          = '0;
        pen_down_next   = (pd_add > 21'(gtl_pkg::HEIGHT_MAX)) ? gtl_pkg::HEIGHT_MAX
                                                              : pd_add[19:0];
        height_sum_next = (hs_add > 21'(gtl_pkg::HEIGHT_MAX)) ? gtl_pkg::HEIGHT_MAX
                                                              : hs_add[19:0];
      end else if (s1_mapped) begin
        lw_fin = (lw_add > 20'(gtl_pkg::LINE_MAX)) ? gtl_pkg::LINE_MAX : lw_add[18:0];
      end
    end
    line_width_next = lw_fin;
    wd_fin          = (lw_fin > widest_next) ? lw_fin : widest_next;
    hs_fin          = height_sum_next;
    // Clear string state after the last byte
    if (meas_hit) begin
      line_width_next = '0;
      widest_next     = '0;
      pen_down_next   = '0;
      height_sum_next = '0;
    end
  end

  assign th_add = 21'(hs_fin) + 21'(line_pitch);
  assign th_sat = (th_add > 21'(gtl_pkg::HEIGHT_MAX)) ? gtl_pkg::HEIGHT_MAX : th_add[19:0];

  // Assemble both kinds of result
  always_comb begin
    res_quad             = '0;
    res_quad.kind        = gtl_pkg::KIND_QUAD;
    res_quad.centre_x    = gtl_pkg::sat_s20(cx_sum);
    res_quad.centre_y    = gtl_pkg::sat_s20(cy_sum);
    res_quad.quad_width  = g_w;
    res_quad.quad_height = g_h;
    res_quad.atlas_rect  = atlas_rdata;
    res_quad.color       = draw_color;

    res_meas             = '0;
    res_meas.kind        = gtl_pkg::KIND_MEASURE;
    res_meas.text_width  = font_ok ? wd_fin : '0;
    res_meas.text_height = font_ok ? th_sat : '0;
    res_meas.last_out    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= '0;
      widest     <= '0;
      pen_down   <= '0;
      height_sum <= '0;
    end else begin
      line_width <= line_width_next;
      widest     <= widest_next;
      pen_down   <= pen_down_next;
      height_sum <= height_sum_next;
    end
  end

  // ------------------------------------------------------------------
  // Result queue
  // ------------------------------------------------------------------
  gtl_pkg::result_t fifo [gtl_pkg::RES_DEPTH];
  gtl_pkg::result_t head;
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [1:0]       push_n;
  logic             pop;
  logic [CW:0]      room_need;

  assign push_n     = {1'b0, quad_hit} + {1'b0, meas_hit};
  assign pop        = result_valid && !result_stall;
  assign count_next = count + CW'(push_n) - CW'(pop);

  // Stall requests unless two results per byte in flight still fit
  assign room_need  = {1'b0, count} + (s1_valid ? (CW+1)'(4) : (CW+1)'(2));
  assign item_stall = rst || (room_need > (CW+1)'(gtl_pkg::RES_DEPTH));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= quad_hit ? res_quad : res_meas;
    end
    if (quad_hit && meas_hit) begin
      fifo[wr_ptr + PW'(1)] <= res_meas;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

  // Drive the result channel from the queue head
  assign head         = fifo[rd_ptr];
  assign result_valid = (count != '0);
  assign kind         = head.kind;
  assign centre_x     = head.centre_x;
  assign centre_y     = head.centre_y;
  assign quad_width   = head.quad_width;
  assign quad_height  = head.quad_height;
  assign atlas_rect   = head.atlas_rect;
  assign color        = head.color;
  assign text_width   = head.text_width;
  assign text_height  = head.text_height;
  assign last_out     = head.last_out;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(gtl_pkg::RES_DEPTH))
    else $error("result queue overflow");

  a_string_clear: assert property (@(posedge clk) disable iff (rst)
    meas_hit |=> (line_width == '0) && (widest == '0) && (pen_down == '0)
                 && (height_sum == '0))
    else $error("string state not cleared after measurement");

  a_measure_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (kind == gtl_pkg::KIND_MEASURE)) |-> last_out)
    else $error("measurement without last mark");

endmodule

FILE: verif/glyph_text_layout_top_tb.sv
// Self-checking bench for glyph_text_layout_top: loads the glyph table, streams
// text strings and checks every quad and string measurement against a predictor.
// Depends on gtl_pkg and the block's RTL only.
`timescale 1ns / 1ps

module glyph_text_layout_top_tb;

  // One request as the sender holds it
  typedef struct {
    logic               cmd;
    logic [7:0]         code;
    logic [15:0]        adv;
    logic signed [15:0] offx;
    logic signed [15:0] offy;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [63:0]        rect;
    logic               last;
  } glyph_req_t;

  localparam int SQUEEZE_CYCLES = 300;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [gtl_pkg::PADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          item_valid = 1'b0;
  logic                          item_stall;
  logic                          cmd = 1'b0;
  logic [7:0]                    code = '0;
  logic [15:0]                   advance_in = '0;
  logic signed [15:0]            offset_x_in = '0;
  logic signed [15:0]            offset_y_in = '0;
  logic [15:0]                   width_in = '0;
  logic [15:0]                   height_in = '0;
  logic [63:0]                   atlas_rect_in = '0;
  logic                          last_char = 1'b0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic                          kind;
  logic signed [19:0]            centre_x;
  logic signed [19:0]            centre_y;
  logic [15:0]                   quad_width;
  logic [15:0]                   quad_height;
  logic [63:0]                   atlas_rect;
  logic [31:0]                   color;
  logic [18:0]                   text_width;
  logic [19:0]                   text_height;
  logic                          last_out;

  glyph_text_layout_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .code(code), .advance_in(advance_in),
    .offset_x_in(offset_x_in), .offset_y_in(offset_y_in),
    .width_in(width_in), .height_in(height_in),
    .atlas_rect_in(atlas_rect_in), .last_char(last_char),
    .result_valid(result_valid), .result_stall(result_stall),
    .kind(kind), .centre_x(centre_x), .centre_y(centre_y),
    .quad_width(quad_width), .quad_height(quad_height),
    .atlas_rect(atlas_rect), .color(color),
    .text_width(text_width), .text_height(text_height), .last_out(last_out)
  );

  always #2 clk = ~clk;

  // Register copies seen by the predictor
  logic [7:0]         cfg_first = gtl_pkg::FIRST_CODE_RST;
  logic [8:0]         cfg_count = '0;
  logic [15:0]        cfg_pitch = '0;
  logic signed [19:0] cfg_org_x = '0;
  logic signed [19:0] cfg_org_y = '0;
  logic [31:0]        cfg_color = gtl_pkg::DRAW_COLOR_RST;
  logic               cfg_font = 1'b0;
  logic               cfg_atlas = 1'b0;

  // Glyph table and pen state of the predictor
  logic [15:0]        tbl_adv  [256];
  logic signed [15:0] tbl_offx [256];
  logic signed [15:0] tbl_offy [256];
  logic [15:0]        tbl_w    [256];
  logic [15:0]        tbl_h    [256];
  logic [63:0]        tbl_rect [256];
  longint             line_w = 0;
  longint             widest = 0;
  longint             pen_y = 0;
  longint             drop_sum = 0;

  glyph_req_t         text_and_loads[$];
  gtl_pkg::result_t   quads_and_sizes[$];
  glyph_req_t         on_wire;
  gtl_pkg::result_t   want;
  int                 error_count = 0;
  int                 tx_gap = 0;
  int                 rx_gap = 0;
  int                 hold_left = 0;
  bit                 squeeze_on = 1'b0;
  bit                 squeeze_done = 1'b0;
  bit                 calm = 1'b0;

  function automatic longint sat_up(input longint v, input longint lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic signed [19:0] clamp_q16(input longint v);
    if (v > 524287) return 20'sh7FFFF;
    if (v < -524288) return 20'sh80000;
    return v[19:0];
  endfunction

  // Work out the results one accepted request causes and queue them
  task automatic lay_out_request(input glyph_req_t r);
    gtl_pkg::result_t res;
    logic             font_ok;
    int               idx;
    longint           px;
    longint           py;
    font_ok = cfg_font && (cfg_count != 0);
    if (r.cmd == gtl_pkg::CMD_LOAD) begin
      tbl_adv[r.code]  = r.adv;
      tbl_offx[r.code] = r.offx;
      tbl_offy[r.code] = r.offy;
      tbl_w[r.code]    = r.w;
      tbl_h[r.code]    = r.h;
      tbl_rect[r.code] = r.rect;
      return;
    end
    if (r.code == gtl_pkg::NEWLINE_CODE) begin
      if (line_w > widest) widest = line_w;
      line_w = 0;
      pen_y = sat_up(pen_y + longint'(cfg_pitch), longint'(gtl_pkg::HEIGHT_MAX));
      drop_sum = sat_up(drop_sum + longint'(cfg_pitch), longint'(gtl_pkg::HEIGHT_MAX));
    end else if (r.code >= cfg_first) begin
      idx = int'(r.code) - int'(cfg_first);
      if (idx < int'(cfg_count)) begin
        // emit a quad only for a drawable glyph with font and atlas ready
        if (tbl_w[idx] != 0 && tbl_h[idx] != 0 && font_ok && cfg_atlas) begin
          px = longint'(cfg_org_x) + line_w + longint'(tbl_offx[idx]);
          py = longint'(cfg_org_y) + pen_y + longint'(tbl_offy[idx]);
          res = '0;
          res.kind = gtl_pkg::KIND_QUAD;
          res.centre_x = clamp_q16((2 * px + longint'(tbl_w[idx])) >>> 1);
          res.centre_y = clamp_q16((2 * py + longint'(tbl_h[idx])) >>> 1);
          res.quad_width = tbl_w[idx];
          res.quad_height = tbl_h[idx];
          res.atlas_rect = tbl_rect[idx];
          res.color = cfg_color;
          quads_and_sizes.push_back(res);
        end
        line_w = sat_up(line_w + longint'(tbl_adv[idx]), longint'(gtl_pkg::LINE_MAX));
      end
    end
    // close the string with its measurement
    if (r.last) begin
      if (line_w > widest) widest = line_w;
      res = '0;
      res.kind = gtl_pkg::KIND_MEASURE;
      res.last_out = 1'b1;
      if (font_ok) begin
        res.text_width = 19'(sat_up(widest, longint'(gtl_pkg::LINE_MAX)));
        res.text_height = 20'(sat_up(drop_sum + longint'(cfg_pitch),
                                     longint'(gtl_pkg::HEIGHT_MAX)));
      end
      quads_and_sizes.push_back(res);
      line_w = 0;
      widest = 0;
      pen_y = 0;
      drop_sum = 0;
    end
  endtask

  task automatic note_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
    if (got !== exp_val) note_error($sformatf("%s is %h, expected %h", name, got, exp_val));
  endtask

  // Two-phase APB write; the predictor copy follows the register
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      gtl_pkg::REG_FIRST_CODE:  cfg_first = val[7:0];
      gtl_pkg::REG_GLYPH_COUNT: cfg_count = val[8:0];
      gtl_pkg::REG_LINE_HEIGHT: cfg_pitch = val[15:0];
      gtl_pkg::REG_ORIGIN_X:    cfg_org_x = val[19:0];
      gtl_pkg::REG_ORIGIN_Y:    cfg_org_y = val[19:0];
      gtl_pkg::REG_DRAW_COLOR:  cfg_color = val;
      gtl_pkg::REG_FONT_READY:  cfg_font = val[0];
      gtl_pkg::REG_ATLAS_READY: cfg_atlas = val[0];
      default: ;
    endcase
  endtask

  function automatic glyph_req_t glyph_req(input logic [7:0] idx, input logic [15:0] adv,
                                           input logic signed [15:0] offx,
                                           input logic signed [15:0] offy,
                                           input logic [15:0] w, input logic [15:0] h,
                                           input logic [63:0] rect, input logic last);
    glyph_req_t r;
    r.cmd = gtl_pkg::CMD_LOAD;
    r.code = idx;
    r.adv = adv;
    r.offx = offx;
    r.offy = offy;
    r.w = w;
    r.h = h;
    r.rect = rect;
    r.last = last;
    return r;
  endfunction

  function automatic glyph_req_t random_glyph(input logic [7:0] idx);
    logic [15:0] adv;
    logic [15:0] w;
    logic [15:0] h;
    adv = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 255));
    w = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    h = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    return glyph_req(idx, adv, 16'($urandom), 16'($urandom), w, h,
                     {$urandom, $urandom}, 1'($urandom));
  endfunction

  // Text byte; the load-only fields carry noise
  function automatic glyph_req_t text_req(input logic [7:0] c, input logic last);
    glyph_req_t r;
    r = glyph_req(c, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), {$urandom, $urandom}, last);
    r.cmd = gtl_pkg::CMD_TEXT;
    return r;
  endfunction

  // Strings of mostly mapped glyphs and newlines, with loads and noise between
  task automatic queue_strings(input int n);
    int         made;
    int         len;
    int         span;
    int         pick;
    logic [7:0] c;
    made = 0;
    span = 256 - int'(cfg_first);
    if (int'(cfg_count) < span) span = int'(cfg_count);
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        text_and_loads.push_back(random_glyph(8'($urandom)));
        made++;
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 19);
          if (pick < 12 && span > 0) c = cfg_first + 8'($urandom_range(0, span - 1));
          else if (pick < 15) c = gtl_pkg::NEWLINE_CODE;
          else c = 8'($urandom);
          text_and_loads.push_back(text_req(c, i == len - 1));
          made++;
        end
      end
    end
  endtask

  // Pick a register setting, biased toward the extremes
  task automatic pick_config();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 32;
      2: v = 255;
      default: v = $urandom_range(0, 255);
    endcase
    write_reg(gtl_pkg::REG_FIRST_CODE, v);
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 1;
      2: v = 256;
      default: v = $urandom_range(1, 256);
    endcase
    write_reg(gtl_pkg::REG_GLYPH_COUNT, v);
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 65535;
      default: v = $urandom_range(0, 65535);
    endcase
    write_reg(gtl_pkg::REG_LINE_HEIGHT, v);
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(0, 3))
        0: v = 32'hFFF8_0000;
        1: v = 32'h0007_FFFF;
        2: v = 0;
        default: begin
          v = $urandom_range(0, 20'hFFFFF);
          v = {{12{v[19]}}, v[19:0]};
        end
      endcase
      write_reg(k == 0 ? gtl_pkg::REG_ORIGIN_X : gtl_pkg::REG_ORIGIN_Y, v);
    end
    write_reg(gtl_pkg::REG_DRAW_COLOR, $urandom);
    write_reg(gtl_pkg::REG_FONT_READY, 32'($urandom_range(0, 3) != 0));
    write_reg(gtl_pkg::REG_ATLAS_READY, 32'($urandom_range(0, 3) != 0));
  endtask

  // Wait until every request is taken and every result has come, then drain
  task automatic settle();
    @(posedge clk);
    #1;
    while (text_and_loads.size() != 0 || item_valid || quads_and_sizes.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (8) @(posedge clk);
    #1;
  endtask

  // Request driver: predict on acceptance, hold while stalled, idle in bursts
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) lay_out_request(on_wire);
      if (item_valid && item_stall) begin
        // hold the stalled request
      end else if (tx_gap > 0) begin
        tx_gap--;
        item_valid <= 1'b0;
      end else if (text_and_loads.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 9);
        item_valid <= 1'b0;
      end else if (text_and_loads.size() != 0) begin
        on_wire = text_and_loads.pop_front();
        cmd <= on_wire.cmd;
        code <= on_wire.code;
        advance_in <= on_wire.adv;
        offset_x_in <= on_wire.offx;
        offset_y_in <= on_wire.offy;
        width_in <= on_wire.w;
        height_in <= on_wire.h;
        atlas_rect_in <= on_wire.rect;
        last_char <= on_wire.last;
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (squeeze_on && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left = SQUEEZE_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      result_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 9);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Result monitor: compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (quads_and_sizes.size() == 0) begin
        note_error("result arrived with nothing expected");
      end else begin
        want = quads_and_sizes.pop_front();
        compare_field("kind", kind, want.kind);
        compare_field("centre_x", centre_x, want.centre_x);
        compare_field("centre_y", centre_y, want.centre_y);
        compare_field("quad_width", quad_width, want.quad_width);
        compare_field("quad_height", quad_height, want.quad_height);
        compare_field("atlas_rect", atlas_rect, want.atlas_rect);
        compare_field("color", color, want.color);
        compare_field("text_width", text_width, want.text_width);
        compare_field("text_height", text_height, want.text_height);
        compare_field("last_out", last_out, want.last_out);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: font not ready gives an all-zero measurement; fill the table
    text_and_loads.push_back(text_req(8'd65, 1'b0));
    text_and_loads.push_back(text_req(gtl_pkg::NEWLINE_CODE, 1'b0));
    text_and_loads.push_back(text_req(8'd65, 1'b1));
    for (int e = 0; e < 256; e++) text_and_loads.push_back(random_glyph(8'(e)));
    settle();

    // Directed: empty glyphs, extreme metrics, rounding, skipped bytes, newlines
    write_reg(gtl_pkg::REG_FIRST_CODE, 32);
    write_reg(gtl_pkg::REG_GLYPH_COUNT, 96);
    write_reg(gtl_pkg::REG_LINE_HEIGHT, 256);
    write_reg(gtl_pkg::REG_ORIGIN_X, 1600);
    write_reg(gtl_pkg::REG_ORIGIN_Y, 800);
    write_reg(gtl_pkg::REG_DRAW_COLOR, 32'h1122_3344);
    write_reg(gtl_pkg::REG_FONT_READY, 1);
    write_reg(gtl_pkg::REG_ATLAS_READY, 1);
    text_and_loads.push_back(glyph_req(8'd0, 16'd64, 16'sd0, 16'sd0, 16'd0, 16'd0, '0, 1'b0));
    text_and_loads.push_back(glyph_req(8'd1, 16'd160, 16'sd2, 16'sd3, 16'd0, 16'd128,
                                       64'h1, 1'b0));
    text_and_loads.push_back(glyph_req(8'd2, 16'd160, 16'sd2, 16'sd3, 16'd128, 16'd0,
                                       64'h2, 1'b0));
    text_and_loads.push_back(glyph_req(8'd3, 16'hFFFF, -16'sd32768, 16'sd32767, 16'hFFFF,
                                       16'hFFFF, '1, 1'b0));
    text_and_loads.push_back(glyph_req(8'd4, 16'd0, 16'sd32767, -16'sd32768, 16'd1, 16'd1,
                                       '0, 1'b0));
    text_and_loads.push_back(glyph_req(8'd5, 16'd144, -16'sd35, -16'sd7, 16'd3, 16'd5,
                                       {$urandom, $urandom}, 1'b1));
    text_and_loads.push_back(text_req(8'd35, 1'b0));
    text_and_loads.push_back(text_req(8'd36, 1'b0));
    text_and_loads.push_back(text_req(8'd37, 1'b0));
    text_and_loads.push_back(text_req(8'd33, 1'b0));
    text_and_loads.push_back(text_req(8'd34, 1'b0));
    text_and_loads.push_back(text_req(8'd32, 1'b0));
    text_and_loads.push_back(text_req(gtl_pkg::NEWLINE_CODE, 1'b0));
    text_and_loads.push_back(text_req(8'd37, 1'b0));
    text_and_loads.push_back(text_req(8'd5, 1'b0));
    text_and_loads.push_back(text_req(8'd200, 1'b0));
    text_and_loads.push_back(text_req(8'd38, 1'b1));
    text_and_loads.push_back(text_req(gtl_pkg::NEWLINE_CODE, 1'b1));
    text_and_loads.push_back(text_req(8'd5, 1'b1));
    settle();

    // Saturate pen, line width, height and both centre coordinates
    write_reg(gtl_pkg::REG_FIRST_CODE, 0);
    write_reg(gtl_pkg::REG_GLYPH_COUNT, 256);
    write_reg(gtl_pkg::REG_LINE_HEIGHT, 65535);
    write_reg(gtl_pkg::REG_ORIGIN_X, 32'h0007_FFFF);
    write_reg(gtl_pkg::REG_ORIGIN_Y, 32'hFFF8_0000);
    write_reg(gtl_pkg::REG_DRAW_COLOR, 0);
    text_and_loads.push_back(glyph_req(8'd200, 16'hFFFF, 16'sd32767, 16'sd32767, 16'hFFFF,
                                       16'hFFFF, '1, 1'b1));
    text_and_loads.push_back(glyph_req(8'd201, 16'd1, -16'sd32768, -16'sd32768, 16'd1,
                                       16'd1, '0, 1'b0));
    text_and_loads.push_back(text_req(8'd201, 1'b0));
    repeat (20) text_and_loads.push_back(text_req(8'd200, 1'b0));
    repeat (18) text_and_loads.push_back(text_req(gtl_pkg::NEWLINE_CODE, 1'b0));
    text_and_loads.push_back(text_req(8'd200, 1'b0));
    text_and_loads.push_back(text_req(8'd201, 1'b1));
    settle();

    // Random phases; squeeze the result side in one, no idling in the last
    for (int p = 0; p < 6; p++) begin
      pick_config();
      if (p == 1) squeeze_on = 1'b1;
      if (p == 5) calm = 1'b1;
      queue_strings(p == 1 ? 60 : 25);
      settle();
    end

    if (quads_and_sizes.size() != 0)
      note_error($sformatf("%0d expected results never arrived", quads_and_sizes.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Overall time limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
